FILE: rtl/core/shot_heat_estimator_defines.svh
// ----------------------------------------------------------------------------
// Shot heat estimator assertion macros
// Shared concurrent assertion forms for the checker of the estimator.
// ----------------------------------------------------------------------------
`ifndef SHOT_HEAT_ESTIMATOR_DEFINES_SVH
`define SHOT_HEAT_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SHE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SHE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/she_pkg.sv
// ----------------------------------------------------------------------------
// Shot heat estimator package
// Item types, configuration types, phase codes and reset values.
// ----------------------------------------------------------------------------
package she_pkg;

    localparam int unsigned HEAT_W  = 20;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned CFG_W   = 20;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_SHOT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLING     = 3'd4;

    // Register reset values
    localparam logic [14:0] RST_TORQUE_THR = 15'd8000;
    localparam logic [14:0] RST_SPEED_THR  = 15'd100;
    localparam logic [15:0] RST_CONFIRM    = 16'd15;
    localparam logic [19:0] RST_HEAT_SHOT  = 20'd10000;
    localparam logic [15:0] RST_COOLING    = 16'd80;

    // Phase codes as seen on the result item
    localparam logic [1:0] PHASE_CODE_NORMAL  = 2'd0;
    localparam logic [1:0] PHASE_CODE_SUSPECT = 2'd1;
    localparam logic [1:0] PHASE_CODE_FIRED   = 2'd2;
    localparam logic [1:0] PHASE_CODE_STOPPED = 2'd3;

    typedef enum logic [3:0] {
        PH_NORMAL  = 4'b0001,
        PH_SUSPECT = 4'b0010,
        PH_FIRED   = 4'b0100,
        PH_STOPPED = 4'b1000
    } t_phase;

    typedef struct packed {
        logic signed [15:0] wheel_torque;
        logic signed [15:0] wheel_speed;
        logic               shooter_off;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        phase;
        logic [HEAT_W-1:0] heat_level;
        logic              shot_counted;
    } t_out_item;

    typedef struct packed {
        logic [14:0]        torque_threshold;
        logic [14:0]        speed_threshold;
        logic [15:0]        confirm_ticks;
        logic [HEAT_W-1:0]  heat_per_shot;
        logic [15:0]        cooling_per_tick;
    } t_cfg;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_NORMAL:  code = PHASE_CODE_NORMAL;
            PH_SUSPECT: code = PHASE_CODE_SUSPECT;
            PH_FIRED:   code = PHASE_CODE_FIRED;
            PH_STOPPED: code = PHASE_CODE_STOPPED;
            default:    code = PHASE_CODE_STOPPED;
        endcase
        return code;
    endfunction

    // Magnitude of a 16-bit two's complement sample; the most negative
    // value yields 32768.
    function automatic logic [16:0] magnitude16(input logic [15:0] v);
        logic [16:0] mag;
        if (v[15]) begin
            mag = 17'h10000 - {1'b0, v};
        end else begin
            mag = {1'b0, v};
        end
        return mag;
    endfunction

endpackage

FILE: rtl/core/she_cfg_regs.sv
// ----------------------------------------------------------------------------
// Shot heat estimator configuration registers
// Holds the five tuning registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module she_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [she_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [she_pkg::CFG_W-1:0]      i_cfg_data,
    output she_pkg::t_cfg                  o_cfg
);
    import she_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.torque_threshold <= RST_TORQUE_THR;
            r_cfg.speed_threshold  <= RST_SPEED_THR;
            r_cfg.confirm_ticks    <= RST_CONFIRM;
            r_cfg.heat_per_shot    <= RST_HEAT_SHOT;
            r_cfg.cooling_per_tick <= RST_COOLING;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TORQUE_THR: r_cfg.torque_threshold <= i_cfg_data[14:0];
                CFG_SPEED_THR:  r_cfg.speed_threshold  <= i_cfg_data[14:0];
                CFG_CONFIRM:    r_cfg.confirm_ticks    <= i_cfg_data[15:0];
                CFG_HEAT_SHOT:  r_cfg.heat_per_shot    <= i_cfg_data[HEAT_W-1:0];
                CFG_COOLING:    r_cfg.cooling_per_tick <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/she_tick_core.sv
// ----------------------------------------------------------------------------
// Shot heat estimator tick core
// Phase machine, phase tick counter and heat store; one tick per advance.
// ----------------------------------------------------------------------------
module she_tick_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  she_pkg::t_in_item  i_item,
    input  she_pkg::t_cfg      i_cfg,
    output she_pkg::t_out_item o_result
);
    import she_pkg::*;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [TICKS_W-1:0]    r_ticks;
    logic [TICKS_W-1:0]    n_ticks;
    logic [HEAT_W-1:0]     r_heat;
    logic [HEAT_W-1:0]     n_heat;

    logic [TICKS_W-1:0]    ticks_inc;
    logic [16:0]           torque_mag;
    logic [16:0]           speed_mag;
    logic [HEAT_W:0]       heat_sum;
    logic [HEAT_W-1:0]     heat_mid;
    logic [HEAT_W-1:0]     cool_ext;
    logic                  shot;

    assign torque_mag = magnitude16(i_item.wheel_torque);
    assign speed_mag  = magnitude16(i_item.wheel_speed);
    assign ticks_inc  = (&r_ticks) ? r_ticks : r_ticks + 1'b1;
    assign heat_sum   = {1'b0, r_heat} + {1'b0, i_cfg.heat_per_shot};
    assign cool_ext   = {{(HEAT_W-16){1'b0}}, i_cfg.cooling_per_tick};

    always_comb begin
        n_phase  = r_phase;
        n_ticks  = ticks_inc;
        heat_mid = r_heat;
        shot     = 1'b0;
        case (r_phase)
            PH_NORMAL: begin
                if (torque_mag >= {2'b00, i_cfg.torque_threshold}) begin
                    n_phase = PH_SUSPECT;
                    n_ticks = '0;
                end else if (i_item.shooter_off) begin
                    n_phase = PH_STOPPED;
                    n_ticks = '0;
                end
            end
            PH_SUSPECT: begin
                if (ticks_inc >= i_cfg.confirm_ticks) begin
                    n_phase = PH_FIRED;
                    n_ticks = '0;
                end
            end
            PH_FIRED: begin
                // saturate the add at full scale
                heat_mid = heat_sum[HEAT_W] ? {HEAT_W{1'b1}} : heat_sum[HEAT_W-1:0];
                shot     = 1'b1;
                n_phase  = PH_NORMAL;
                n_ticks  = '0;
            end
            PH_STOPPED: begin
                if (speed_mag >= {2'b00, i_cfg.speed_threshold}) begin
                    n_phase = PH_NORMAL;
                    n_ticks = '0;
                end
            end
            default: begin
                n_phase = PH_STOPPED;
                n_ticks = '0;
            end
        endcase
        // cool last, floor at zero
        n_heat = (heat_mid > cool_ext) ? heat_mid - cool_ext : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STOPPED;
            r_ticks <= '0;
            r_heat  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_heat  <= n_heat;
        end
    end

    assign o_result.phase        = phase_code(n_phase);
    assign o_result.heat_level   = n_heat;
    assign o_result.shot_counted = shot;

endmodule

FILE: rtl/core/shot_heat_estimator.sv
// ----------------------------------------------------------------------------
// Shot heat estimator
// Per-tick barrel heat estimate for a friction-wheel shooter.
// ----------------------------------------------------------------------------
// Each input item is one control tick (torque, speed, shooter-off flag) and
// yields exactly one result item (phase, heat in milli-units, shot flag).
// The block takes one item per clock cycle when the output side keeps up;
// an input register and a result register bracket the combinational tick
// logic. Phase machine and heat state advance as an item moves from the
// input register into the result register, so the next item always sees
// the state left by the previous one. Configuration writes take effect on
// the next edge and are meant to happen only while no item is in flight.
// ----------------------------------------------------------------------------
module shot_heat_estimator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [she_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [she_pkg::CFG_W-1:0]      i_cfg_data,
    // tick input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  she_pkg::t_in_item              i_in_item,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output she_pkg::t_out_item             o_out_item
);
    import she_pkg::*;

    t_cfg       cfg;
    t_out_item  result;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic       out_free;   // result register can take a new item
    logic       advance;    // item moves from input register to result register
    logic       in_take;    // input channel handshake completes

    she_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    she_tick_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // The result register frees up when empty or when its item is taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    // Stall the input only while a held item cannot move on.
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register: valid bit under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register: load on advance, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/core/she_checker.sv
// ----------------------------------------------------------------------------
// Shot heat estimator checker
// Port-level assertions on result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "shot_heat_estimator_defines.svh"

module she_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [she_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [she_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  she_pkg::t_in_item              i_in_item,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  she_pkg::t_out_item             o_out_item
);
    import she_pkg::*;

    logic              out_take;
    logic [1:0]        r_last_phase;
    logic [HEAT_W-1:0] r_last_heat;
    logic              cfg_seen;
    logic              in_seen;

    assign out_take = o_out_valid && !i_out_stall;
    // keep the remaining ports observed
    assign cfg_seen = i_cfg_wr_en && (i_cfg_index == CFG_TORQUE_THR) && (|i_cfg_data);
    assign in_seen  = i_in_valid && !o_in_stall && i_in_item.shooter_off;

    // Track the last delivered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= PHASE_CODE_STOPPED;
            r_last_heat  <= '0;
        end else if (out_take) begin
            r_last_phase <= o_out_item.phase;
            r_last_heat  <= o_out_item.heat_level;
        end
    end

    `SHE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item),
        "stalled result item changed")

    `SHE_ASSERT_NOW(a_shot_after_fired, i_clk, i_rst_n,
        out_take && o_out_item.shot_counted,
        r_last_phase == PHASE_CODE_FIRED,
        "shot counted without a fired phase before")

    `SHE_ASSERT_NOW(a_fired_gives_shot, i_clk, i_rst_n,
        out_take && (r_last_phase == PHASE_CODE_FIRED),
        o_out_item.shot_counted && (o_out_item.phase == PHASE_CODE_NORMAL),
        "fired phase not followed by a shot in normal phase")

    `SHE_ASSERT_NOW(a_heat_only_cools, i_clk, i_rst_n,
        out_take && !o_out_item.shot_counted && !cfg_seen && !in_seen,
        o_out_item.heat_level <= r_last_heat,
        "heat rose without a shot")

endmodule

bind shot_heat_estimator she_checker u_she_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_wr_en (i_cfg_wr_en),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: sim/shot_heat_estimator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shot heat estimator testbench
// Drives tick items through the estimator under random idling and stalls,
// predicts each result item from a local model of the phase machine and heat
// store, and compares every result item field by field in arrival order.
// ----------------------------------------------------------------------------
module shot_heat_estimator_tb;

    import she_pkg::*;

    localparam int unsigned IDLE_LIMIT     = 1000; // cycles with no item moving
    localparam int unsigned RX_HOLD_CYCLES = 60;   // long output hold-off
    localparam int unsigned SETTLE_CYCLES  = 6;    // settle time after draining
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [HEAT_W-1:0] HEAT_FULL  = '1;
    localparam logic [15:0]       TICKS_FULL = '1;

    // Register indexes that do not exist; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_W-1:0]      cfg_data   = '0;
    logic                  tick_valid = 1'b0;
    t_in_item              tick_item  = '0;
    logic                  rx_stall   = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    shot_heat_estimator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (tick_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (tick_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (rx_stall),
        .o_out_item  (o_out_item)
    );

    // ------------------------------------------------------------------------
    // Heat model: own copy of the registers and the estimator state
    // ------------------------------------------------------------------------
    t_cfg              est_cfg;
    logic [1:0]        est_phase;
    logic [15:0]       est_ticks;
    logic [HEAT_W-1:0] est_heat;

    t_out_item   heat_expect_q[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;

    // Idling controls shared by the sender task and the receiver process
    bit          tx_idle_en    = 1'b1;
    bit          rx_idle_en    = 1'b1;
    bit          rx_hold_go    = 1'b0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_burst_left = 0;
    int unsigned quiet_cycles  = 0;

    task automatic model_reset();
        est_cfg.torque_threshold = RST_TORQUE_THR;
        est_cfg.speed_threshold  = RST_SPEED_THR;
        est_cfg.confirm_ticks    = RST_CONFIRM;
        est_cfg.heat_per_shot    = RST_HEAT_SHOT;
        est_cfg.cooling_per_tick = RST_COOLING;
        est_phase = PHASE_CODE_STOPPED;
        est_ticks = '0;
        est_heat  = '0;
    endtask

    function automatic void enter_phase(input logic [1:0] next_phase);
        est_phase = next_phase;
        est_ticks = '0;
    endfunction

    // Advance the model by one tick and return the result item it yields
    function automatic t_out_item predict_tick(input t_in_item it);
        t_out_item   res;
        logic [16:0] tq_mag;
        logic [16:0] sp_mag;
        logic [20:0] sum;
        logic        shot;
        // magnitude of the most negative sample is 32768
        tq_mag = it.wheel_torque[15] ? 17'h10000 - {1'b0, it.wheel_torque}
                                     : {1'b0, it.wheel_torque};
        sp_mag = it.wheel_speed[15]  ? 17'h10000 - {1'b0, it.wheel_speed}
                                     : {1'b0, it.wheel_speed};
        shot = 1'b0;
        // tick counter saturates instead of wrapping
        if (est_ticks != TICKS_FULL) begin
            est_ticks = est_ticks + 16'd1;
        end
        case (est_phase)
            PHASE_CODE_NORMAL: begin
                if (tq_mag >= {2'b00, est_cfg.torque_threshold}) begin
                    enter_phase(PHASE_CODE_SUSPECT);
                end else if (it.shooter_off) begin
                    enter_phase(PHASE_CODE_STOPPED);
                end
            end
            PHASE_CODE_SUSPECT: begin
                if (est_ticks >= est_cfg.confirm_ticks) begin
                    enter_phase(PHASE_CODE_FIRED);
                end
            end
            PHASE_CODE_FIRED: begin
                sum = {1'b0, est_heat} + {1'b0, est_cfg.heat_per_shot};
                est_heat = (sum > {1'b0, HEAT_FULL}) ? HEAT_FULL : sum[HEAT_W-1:0];
                shot = 1'b1;
                enter_phase(PHASE_CODE_NORMAL);
            end
            default: begin
                if (sp_mag >= {2'b00, est_cfg.speed_threshold}) begin
                    enter_phase(PHASE_CODE_NORMAL);
                end
            end
        endcase
        // cool last, floor at zero
        if (est_heat != '0) begin
            if (est_heat > {4'b0, est_cfg.cooling_per_tick}) begin
                est_heat = est_heat - {4'b0, est_cfg.cooling_per_tick};
            end else begin
                est_heat = '0;
            end
        end
        res.phase        = est_phase;
        res.heat_level   = est_heat;
        res.shot_counted = shot;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one item, hold it until accepted, then maybe idle a burst.
    // Valid is left high when no gap follows so back-to-back items flow.
    task automatic send_tick(input t_in_item it);
        int unsigned gap;
        tick_item  <= it;
        tick_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        heat_expect_q.push_back(predict_tick(it));
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            tick_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input int tq, input int sp, input bit off);
        t_in_item it;
        it.wheel_torque = 16'(tq);
        it.wheel_speed  = 16'(sp);
        it.shooter_off  = off;
        send_tick(it);
    endtask

    // Drop valid and wait until every expected item is back, then settle
    task automatic drain_results();
        tick_valid <= 1'b0;
        @(posedge i_clk);
        while (heat_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        // keep only the low bits of each register's width
        case (idx)
            CFG_TORQUE_THR: est_cfg.torque_threshold = data[14:0];
            CFG_SPEED_THR:  est_cfg.speed_threshold  = data[14:0];
            CFG_CONFIRM:    est_cfg.confirm_ticks    = data[15:0];
            CFG_HEAT_SHOT:  est_cfg.heat_per_shot    = data[HEAT_W-1:0];
            CFG_COOLING:    est_cfg.cooling_per_tick = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [CFG_W-1:0] tq_thr,
                                  input logic [CFG_W-1:0] sp_thr,
                                  input logic [CFG_W-1:0] confirm,
                                  input logic [CFG_W-1:0] heat,
                                  input logic [CFG_W-1:0] cool);
        write_reg(CFG_TORQUE_THR, tq_thr);
        write_reg(CFG_SPEED_THR,  sp_thr);
        write_reg(CFG_CONFIRM,    confirm);
        write_reg(CFG_HEAT_SHOT,  heat);
        write_reg(CFG_COOLING,    cool);
    endtask

    // Random tick shaped around the current thresholds: mostly quiet torque
    // with spikes, so the phase machine keeps cycling through a shot.
    function automatic t_in_item rand_tick();
        t_in_item    it;
        int unsigned tq_thr;
        int unsigned sp_thr;
        int unsigned pick;
        logic [15:0] mag;
        tq_thr = 32'(est_cfg.torque_threshold);
        sp_thr = 32'(est_cfg.speed_threshold);
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
            mag = (tq_thr == 0) ? 16'd0 : 16'($urandom_range(0, tq_thr - 1));
            it.wheel_torque = $urandom_range(0, 1) ? -mag : mag;
        end else if (pick < 17) begin
            it.wheel_torque = 16'($urandom);
        end else if (pick == 17) begin
            mag = 16'(tq_thr);
            it.wheel_torque = $urandom_range(0, 1) ? -mag : mag;
        end else begin
            it.wheel_torque = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            it.wheel_speed = 16'($urandom);
        end else if (pick == 7) begin
            mag = (sp_thr == 0) ? 16'd0 : 16'($urandom_range(0, sp_thr - 1));
            it.wheel_speed = $urandom_range(0, 1) ? -mag : mag;
        end else if (pick == 8) begin
            mag = 16'(sp_thr);
            it.wheel_speed = $urandom_range(0, 1) ? -mag : mag;
        end else begin
            it.wheel_speed = $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
        end
        it.shooter_off = ($urandom_range(0, 15) == 0);
        return it;
    endfunction

    task automatic send_random(input int unsigned count);
        repeat (count) send_tick(rand_tick());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: stopped phase, default speed and torque thresholds
    task automatic test_reset_values();
        send_fields(0, 99, 1'b0);       // below speed threshold, stay stopped
        send_fields(0, -100, 1'b0);     // speed magnitude at threshold, go normal
        send_fields(7999, 0, 1'b0);     // torque just below threshold
        send_fields(-8000, 0, 1'b0);    // torque magnitude at threshold, suspect
        drain_results();
    endtask

    // Zero confirm time, heat saturation, most negative samples, register
    // truncation, ignored indexes and cooling floor
    task automatic test_special_cases();
        write_reg(CFG_TORQUE_THR, 20'hFFFFF);   // truncates to 32767
        write_reg(CFG_SPEED_THR,  20'hF7FFF);   // truncates to 32767
        write_reg(CFG_CONFIRM,    20'hF0000);   // truncates to zero
        write_reg(CFG_HEAT_SHOT,  20'hFFFFF);
        write_reg(CFG_COOLING,    20'h00001);
        write_reg(CFG_UNUSED_5,   20'h00000);
        write_reg(CFG_UNUSED_7,   20'hFFFFF);
        send_fields(0, 0, 1'b0);              // suspect confirms at once
        send_fields(0, 0, 1'b0);              // fired: add full heat
        send_fields(-32768, 0, 1'b0);         // magnitude 32768 meets threshold
        send_fields(0, 0, 1'b0);
        send_fields(0, 0, 1'b0);              // second add saturates
        send_fields(32767, 0, 1'b1);          // torque wins over shooter off
        send_fields(-1, 0, 1'b0);
        send_fields(0, 0, 1'b0);
        send_fields(0, 0, 1'b1);              // shooter off, go stopped
        send_fields(0, 32766, 1'b0);          // speed just short
        send_fields(-1, -32768, 1'b0);        // most negative speed, go normal
        send_fields(-32767, 32767, 1'b0);
        drain_results();
        write_reg(CFG_COOLING, 20'h0FFFF);
        write_reg(CFG_HEAT_SHOT, 20'h00000);
        send_fields(0, 0, 1'b1);
        send_fields(0, 0, 1'b1);
        send_fields(0, 0, 1'b1);
        drain_results();
    endtask

    // Several register settings, extremes among them, with random idling
    task automatic test_random_settings();
        write_all_regs(20'(RST_TORQUE_THR), 20'(RST_SPEED_THR), 20'(RST_CONFIRM),
                       RST_HEAT_SHOT, 20'(RST_COOLING));
        send_random(300);
        drain_results();
        write_all_regs(20'd0, 20'd0, 20'd1, 20'd1, 20'd0);
        send_random(250);
        drain_results();
        write_all_regs(20'd32767, 20'd32767, 20'd2, 20'hFFFFF, 20'h0FFFF);
        send_random(250);
        drain_results();
        write_all_regs(20'($urandom_range(1, 32767)), 20'($urandom_range(0, 32767)),
                       20'($urandom_range(1, 40)), 20'($urandom_range(0, 20'hFFFFF)),
                       20'($urandom_range(0, 2000)));
        send_random(300);
        drain_results();
        // raw random writes: upper bits dropped, unused indexes ignored
        write_all_regs(20'($urandom), 20'($urandom), 20'($urandom_range(0, 8)),
                       20'($urandom), 20'($urandom_range(0, 500)));
        write_reg(CFG_UNUSED_5, 20'($urandom));
        send_random(250);
        drain_results();
    endtask

    // Hold the output side for a long stretch while items keep coming, so
    // the block fills and stalls its input; then pause until all are back and send more items with idle gaps.
    task automatic test_backpressure();
        write_all_regs(20'd3000, 20'd50, 20'd4, 20'd30000, 20'd100);
        tx_idle_en = 1'b0;
        rx_hold_go = 1'b1;
        send_random(150);
        drain_results();
        tx_idle_en = 1'b1;
        send_random(100);
        drain_results();
    endtask

    // Final stretch with both sides always ready
    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_all_regs(20'd5000, 20'd200, 20'd6, 20'd70000, 20'd300);
        send_random(350);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts plus an on-request long hold
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_go) begin
            rx_hold_go   = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            rx_stall <= 1'b1;
        end else if (rx_burst_left > 0) begin
            rx_burst_left--;
            rx_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            rx_burst_left = $urandom_range(1, 6) - 1;
            rx_stall <= 1'b1;
        end else begin
            rx_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted item against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && !rx_stall) begin
            results_seen++;
            if (heat_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result item %0d: phase %0d heat %0d shot %0d",
                             results_seen, o_out_item.phase, o_out_item.heat_level,
                             o_out_item.shot_counted);
                end
            end else begin
                exp_item = heat_expect_q.pop_front();
                if (o_out_item.phase !== exp_item.phase ||
                    o_out_item.heat_level !== exp_item.heat_level ||
                    o_out_item.shot_counted !== exp_item.shot_counted) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"mismatch item %0d: phase %0d/%0d heat %0d/%0d ",
                                  "shot %0d/%0d (exp/got)"},
                                 results_seen, exp_item.phase, o_out_item.phase,
                                 exp_item.heat_level, o_out_item.heat_level,
                                 exp_item.shot_counted, o_out_item.shot_counted);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no item moves on either side for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_valid && !o_in_stall) || (o_out_valid && !rx_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        model_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_special_cases();
        test_random_settings();
        test_backpressure();
        test_full_rate();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && heat_expect_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
